// ===== src/rangefinder_reply_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Range-finder reply parser assertion macros
// Short forms for the concurrent checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RANGEFINDER_REPLY_PARSER_ASSERT_SVH
`define RANGEFINDER_REPLY_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rangefinder reply parser: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rangefinder reply parser: next-cycle check failed");

`endif

// ===== src/rrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Range-finder reply parser package
// Types and constants shared by the parser modules and the testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package rrp_pkg;

   localparam int DataBytes  = 6;
   localparam int MeasWidth  = DataBytes * 8;
   localparam int EventWidth = 3;

   typedef logic [7:0] byte_type;

   typedef enum logic [2:0] {
      MODE_GREETING = 3'd0,
      MODE_WAIT     = 3'd1,
      MODE_STARTED  = 3'd2,
      MODE_DATA     = 3'd3,
      MODE_ACKCFG   = 3'd4
   } mode_type;

   typedef enum logic [EventWidth-1:0] {
      EV_PROGRESS = 3'd0,
      EV_GREETING = 3'd1,
      EV_MEAS     = 3'd2,
      EV_ACK      = 3'd3,
      EV_REJECT   = 3'd4
   } event_type;

   localparam byte_type SyncByte = 8'h59;
   localparam byte_type AckByte  = 8'h3C;
   localparam byte_type CmdMeas  = 8'hDA;
   localparam byte_type CmdPtr   = 8'hC5;
   localparam byte_type SumXor   = 8'h50;
   localparam byte_type LineFeed = 8'h0A;

   localparam logic [3:0] OffsetSync  = 4'd1;
   localparam logic [3:0] OffsetFirst = 4'd2;
   localparam logic [3:0] OffsetAck   = 4'd3;
   localparam logic [3:0] OffsetCheck = 4'd8;

   typedef struct packed {
      mode_type                       mode;
      logic [3:0]                     offset;
      byte_type                       sum;
      logic [DataBytes-1:0][7:0]      store;
      logic                           data_flag;
      logic                           ack_flag;
   } parse_state_type;

endpackage

`default_nettype wire

// ===== src/rrp_req_if.sv =====
// ----------------------------------------------------------------------------
// Range-finder reply parser request channel
// Valid/ready channel carrying one received byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== src/rrp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Range-finder reply parser response channel
// Valid/ready channel carrying the event code, flags and measurement bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic        data_ready;
   logic        config_ok;
   logic [47:0] measurement;

   modport source (output valid, output event_res, output data_ready,
                   output config_ok, output measurement, input ready);
   modport sink   (input valid, input event_res, input data_ready,
                   input config_ok, input measurement, output ready);
endinterface

`default_nettype wire

// ===== src/rrp_step.sv =====
// ----------------------------------------------------------------------------
// Range-finder reply parser step logic
// Works out the next parser state and the event code for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rrp_step (
   input  rrp_pkg::parse_state_type cur_state,
   input  rrp_pkg::byte_type        rx_byte,
   output rrp_pkg::parse_state_type nxt_state,
   output rrp_pkg::event_type       event_code
);
   import rrp_pkg::*;

   logic [3:0] data_index;

   assign data_index = cur_state.offset - OffsetFirst;

   always_comb begin
      nxt_state  = cur_state;
      event_code = EV_PROGRESS;
      unique case (cur_state.mode)
         MODE_GREETING: begin
            if (rx_byte == LineFeed) begin
               nxt_state.mode = MODE_WAIT;
               event_code     = EV_GREETING;
            end
            nxt_state.offset = '0;
         end
         MODE_STARTED: begin
            nxt_state.sum = cur_state.sum + rx_byte;
            if (rx_byte == CmdMeas) begin
               nxt_state.mode   = MODE_DATA;
               nxt_state.offset = OffsetFirst;
            end else if (rx_byte == CmdPtr) begin
               nxt_state.mode   = MODE_ACKCFG;
               nxt_state.offset = OffsetFirst;
            end else begin
               nxt_state.mode   = MODE_WAIT;
               nxt_state.offset = '0;
               event_code       = EV_REJECT;
            end
         end
         MODE_DATA: begin
            if (cur_state.offset < OffsetCheck) begin
               nxt_state.sum = cur_state.sum + rx_byte;
               if (data_index < 4'(DataBytes)) begin
                  nxt_state.store[data_index[2:0]] = rx_byte;
               end
               nxt_state.offset = cur_state.offset + 4'd1;
            end else begin
               nxt_state.data_flag = ((cur_state.sum ^ SumXor) == rx_byte);
               nxt_state.mode      = MODE_WAIT;
               nxt_state.offset    = '0;
               event_code          = EV_MEAS;
            end
         end
         MODE_ACKCFG: begin
            if (cur_state.offset < OffsetAck) begin
               nxt_state.sum = cur_state.sum + rx_byte;
               if (rx_byte != AckByte) begin
                  nxt_state.mode   = MODE_WAIT;
                  nxt_state.offset = '0;
                  event_code       = EV_REJECT;
               end else begin
                  nxt_state.offset = cur_state.offset + 4'd1;
               end
            end else begin
               nxt_state.ack_flag = ((cur_state.sum ^ SumXor) == rx_byte);
               nxt_state.mode     = MODE_WAIT;
               nxt_state.offset   = '0;
               event_code         = EV_ACK;
            end
         end
         default: begin
            nxt_state.sum = rx_byte;
            if (rx_byte == SyncByte) begin
               nxt_state.mode   = MODE_STARTED;
               nxt_state.offset = OffsetSync;
            end else begin
               nxt_state.mode   = MODE_WAIT;
               nxt_state.offset = '0;
               event_code       = EV_REJECT;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/rangefinder_reply_parser.sv =====
// ----------------------------------------------------------------------------
// Range-finder reply parser
// Byte-serial parser for measurement and acknowledge replies of a range-finder.
// ----------------------------------------------------------------------------
// Bytes enter on the req_port channel, one byte per word, and every byte gives
// exactly one word on the rsp_port channel: an event code, the two checksum
// flags and the six stored measurement bytes as they stand after that byte.
// A byte is first held in an input register; the parser logic then turns it
// into the result register, once that register is empty or being taken. One
// byte per cycle is sustained while the receiver takes results; the state
// update is a single pass through the parser logic.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more byte, so the sender sees ready drop only
// once both are full. A synchronous reset empties both registers and puts the
// parser back in the greeting line, with the flags and stored bytes cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rangefinder_reply_parser (
   input  wire         clock,
   input  wire         reset,
   rrp_req_if.sink     req_port,
   rrp_rsp_if.source   rsp_port
);
   import rrp_pkg::*;

   `include "rangefinder_reply_parser_assert.svh"

   logic            in_valid_ff;
   byte_type        in_byte_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   event_type       event_in;
   logic            out_valid_ff;
   logic [2:0]      event_ff;
   logic            data_ready_ff;
   logic            config_ok_ff;
   logic [47:0]     measurement_ff;
   logic            advance;
   logic            req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_take = req_port.valid && req_port.ready;

   assign req_port.ready = !in_valid_ff || advance;

   rrp_step u_step (
      .cur_state  (state_ff),
      .rx_byte    (in_byte_ff),
      .nxt_state  (state_in),
      .event_code (event_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         state_ff.mode       <= MODE_GREETING;
         state_ff.offset     <= '0;
         state_ff.sum        <= '0;
         state_ff.store      <= '0;
         state_ff.data_flag  <= 1'b0;
         state_ff.ack_flag   <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_port.rx_byte;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff       <= state_in;
            out_valid_ff   <= 1'b1;
            event_ff       <= event_in;
            data_ready_ff  <= state_in.data_flag;
            config_ok_ff   <= state_in.ack_flag;
            measurement_ff <= state_in.store;
         end else if (rsp_port.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.event_res   = event_ff;
   assign rsp_port.data_ready  = data_ready_ff;
   assign rsp_port.config_ok   = config_ok_ff;
   assign rsp_port.measurement = measurement_ff;

   `RRP_ASSERT_NEXT(a_stall_holds, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `RRP_ASSERT_NEXT(a_frame_end_waits, clock, reset,
      advance && (event_in == EV_MEAS || event_in == EV_ACK), state_ff.mode == MODE_WAIT)
   `RRP_ASSERT_NEXT(a_no_greeting_return, clock, reset,
      state_ff.mode != MODE_GREETING, state_ff.mode != MODE_GREETING)
   `RRP_ASSERT_NEXT(a_data_flag_on_meas, clock, reset,
      !(advance && event_in == EV_MEAS), $stable(state_ff.data_flag))

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Range-finder reply parser testbench
// Sends greeting, measurement, acknowledge and corrupt reply bytes into the
// parser and checks every result word against a predictor of the parser
// state, with random gaps on both channels and one long receiver stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rrp_pkg::*;

   localparam byte_type CmdStatus = 8'hC7;

   typedef struct packed {
      event_type              ev;
      logic                   data_ready;
      logic                   config_ok;
      logic [MeasWidth-1:0]   meas;
   } reply_type;

   logic clock;
   logic reset;

   rrp_req_if req_bus ();
   rrp_rsp_if rsp_bus ();

   rangefinder_reply_parser i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   mode_type                    cur_mode;
   logic [3:0]                  cur_offset;
   byte_type                    run_sum;
   logic [DataBytes-1:0][7:0]   held_bytes;
   logic                        meas_ok;
   logic                        ack_ok;

   reply_type   due_replies[$];
   bit          idling_on = 1'b1;
   int unsigned hold_cycles = 0;
   int unsigned bytes_sent = 0;
   int unsigned words_seen = 0;
   int unsigned error_count = 0;
   int unsigned greetings_seen = 0;
   int unsigned meas_frames = 0;
   int unsigned meas_good = 0;
   int unsigned ack_frames = 0;
   int unsigned ack_good = 0;
   int unsigned rejects_seen = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("FAILURE");
      $finish;
   end

   function automatic void parse_byte(input byte_type rx);
      reply_type   r;
      event_type   ev;
      int          slot;
      ev = EV_PROGRESS;
      case (cur_mode)
         MODE_GREETING: begin
            if (rx == LineFeed) begin
               cur_mode = MODE_WAIT;
               ev       = EV_GREETING;
            end
            cur_offset = '0;
         end
         MODE_STARTED: begin
            run_sum = run_sum + rx;
            if (rx == CmdMeas) begin
               cur_mode   = MODE_DATA;
               cur_offset = OffsetFirst;
            end else if (rx == CmdPtr) begin
               cur_mode   = MODE_ACKCFG;
               cur_offset = OffsetFirst;
            end else begin
               cur_mode   = MODE_WAIT;
               cur_offset = '0;
               ev         = EV_REJECT;
            end
         end
         MODE_DATA: begin
            if (cur_offset < OffsetCheck) begin
               slot             = int'(cur_offset - OffsetFirst);
               run_sum          = run_sum + rx;
               held_bytes[slot] = rx;
               cur_offset       = cur_offset + 4'd1;
            end else begin
               meas_ok    = ((run_sum ^ SumXor) == rx);
               cur_mode   = MODE_WAIT;
               cur_offset = '0;
               ev         = EV_MEAS;
            end
         end
         MODE_ACKCFG: begin
            if (cur_offset < OffsetAck) begin
               run_sum = run_sum + rx;
               if (rx != AckByte) begin
                  cur_mode   = MODE_WAIT;
                  cur_offset = '0;
                  ev         = EV_REJECT;
               end else begin
                  cur_offset = cur_offset + 4'd1;
               end
            end else begin
               ack_ok     = ((run_sum ^ SumXor) == rx);
               cur_mode   = MODE_WAIT;
               cur_offset = '0;
               ev         = EV_ACK;
            end
         end
         default: begin
            run_sum = rx;
            if (rx == SyncByte) begin
               cur_mode   = MODE_STARTED;
               cur_offset = OffsetSync;
            end else begin
               cur_mode   = MODE_WAIT;
               cur_offset = '0;
               ev         = EV_REJECT;
            end
         end
      endcase
      r.ev         = ev;
      r.data_ready = meas_ok;
      r.config_ok  = ack_ok;
      r.meas       = held_bytes;
      due_replies.push_back(r);
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("Mismatch in %s at word %0d: got 0x%0h, expected 0x%0h",
               field, words_seen, got, want);
      error_count++;
   endtask

   task automatic send_byte(input byte_type rx);
      while (idling_on && $urandom_range(99) < 27) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= rx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      parse_byte(rx);
      bytes_sent++;
   endtask

   task automatic send_meas_frame(input logic [MeasWidth-1:0] data, input bit good);
      byte_type sum;
      sum = SyncByte + CmdMeas;
      send_byte(SyncByte);
      send_byte(CmdMeas);
      for (int i = 0; i < DataBytes; i++) begin
         send_byte(data[8*i +: 8]);
         sum = sum + data[8*i +: 8];
      end
      sum = sum ^ SumXor;
      if (!good) sum = sum ^ byte_type'($urandom_range(255, 1));
      send_byte(sum);
   endtask

   task automatic send_ack_frame(input bit good);
      byte_type sum;
      sum = (SyncByte + CmdPtr + AckByte) ^ SumXor;
      if (!good) sum = sum ^ byte_type'($urandom_range(255, 1));
      send_byte(SyncByte);
      send_byte(CmdPtr);
      send_byte(AckByte);
      send_byte(sum);
   endtask

   task automatic send_random_sequence();
      int unsigned pick;
      byte_type    odd;
      pick = $urandom_range(99);
      if (pick < 45) begin
         send_meas_frame({32'($urandom), 16'($urandom_range(65535))},
                         $urandom_range(99) < 80);
      end else if (pick < 70) begin
         send_ack_frame($urandom_range(99) < 80);
      end else if (pick < 80) begin
         odd = ($urandom_range(3) == 0) ? SyncByte : byte_type'($urandom);
         if (odd == CmdMeas || odd == CmdPtr) odd = CmdStatus;
         send_byte(SyncByte);
         send_byte(odd);
      end else if (pick < 90) begin
         odd = ($urandom_range(3) == 0) ? SyncByte : byte_type'($urandom);
         if (odd == AckByte) odd = ~AckByte;
         send_byte(SyncByte);
         send_byte(CmdPtr);
         send_byte(odd);
      end else begin
         repeat ($urandom_range(3, 1)) send_byte(byte_type'($urandom));
      end
   endtask

   task automatic test_greeting();
      send_byte(SyncByte);
      send_byte(8'h00);
      send_byte(LineFeed);
   endtask

   task automatic test_sync_hunt();
      send_byte(8'hFF);
   endtask

   task automatic test_measurement_frame();
      send_meas_frame(48'hFE01_7F80_FF00, 1'b1);
   endtask

   task automatic test_unknown_command();
      send_byte(SyncByte);
      send_byte(CmdStatus);
   endtask

   task automatic test_ack_frame();
      send_ack_frame(1'b1);
   endtask

   task automatic test_wrong_ack();
      send_byte(SyncByte);
      send_byte(CmdPtr);
      send_byte(8'h00);
   endtask

   task automatic test_failed_checksum();
      send_ack_frame(1'b0);
   endtask

   task automatic test_random_traffic(input int unsigned count);
      int unsigned target;
      target = bytes_sent + count;
      while (bytes_sent < target) send_random_sequence();
   endtask

   task automatic test_backpressure();
      logic [MeasWidth-1:0] data;
      data        = {32'($urandom), 16'($urandom_range(65535))};
      hold_cycles = 60;
      send_meas_frame(data, 1'b1);
      send_ack_frame(1'b1);
      send_meas_frame(~data, 1'b0);
   endtask

   task automatic test_steady_stream();
      idling_on = 1'b0;
      test_random_traffic(120);
      idling_on = 1'b1;
   endtask

   initial begin : reply_monitor
      reply_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            words_seen++;
            if (due_replies.size() == 0) begin
               report_mismatch("word with none expected", 64'(rsp_bus.event_res), 64'(0));
            end else begin
               want = due_replies.pop_front();
               if (rsp_bus.event_res !== want.ev)
                  report_mismatch("event_res", 64'(rsp_bus.event_res), 64'(want.ev));
               if (rsp_bus.data_ready !== want.data_ready)
                  report_mismatch("data_ready", 64'(rsp_bus.data_ready),
                                  64'(want.data_ready));
               if (rsp_bus.config_ok !== want.config_ok)
                  report_mismatch("config_ok", 64'(rsp_bus.config_ok),
                                  64'(want.config_ok));
               if (rsp_bus.measurement !== want.meas)
                  report_mismatch("measurement", 64'(rsp_bus.measurement), 64'(want.meas));
               case (want.ev)
                  EV_GREETING: greetings_seen++;
                  EV_MEAS: begin
                     meas_frames++;
                     if (want.data_ready) meas_good++;
                  end
                  EV_ACK: begin
                     ack_frames++;
                     if (want.config_ok) ack_good++;
                  end
                  EV_REJECT: rejects_seen++;
                  default: ;
               endcase
            end
         end
         if (hold_cycles != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_bus.ready <= !(idling_on && $urandom_range(99) < 27);
         end
      end
   end

   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      reset           <= 1'b1;
      cur_mode   = MODE_GREETING;
      cur_offset = '0;
      run_sum    = '0;
      held_bytes = '0;
      meas_ok    = 1'b0;
      ack_ok     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_greeting();
      test_sync_hunt();
      test_measurement_frame();
      test_unknown_command();
      test_ack_frame();
      test_wrong_ack();
      test_failed_checksum();
      test_random_traffic(300);
      test_backpressure();
      test_steady_stream();
      test_random_traffic(110);

      req_bus.valid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes and checked %0d result words.", bytes_sent, words_seen);
      $display("Seen %0d greeting ends, %0d measurement frames (%0d good),",
               greetings_seen, meas_frames, meas_good);
      $display("%0d ack frames (%0d good) and %0d rejected bytes.",
               ack_frames, ack_good, rejects_seen);
      if (error_count == 0 && due_replies.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== rangefinder_reply_parser.f =====
+incdir+src
src/rrp_pkg.sv
src/rrp_req_if.sv
src/rrp_rsp_if.sv
src/rrp_step.sv
src/rangefinder_reply_parser.sv
test/tb_top.sv
